FILE: hw/rtl/smec_pkg.sv
// ----------------------------------------------------------------------------
// smec_pkg
// Codes and control types shared by the shuttle motor end-stop controller.
// ----------------------------------------------------------------------------
package smec_pkg;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_SET_MODE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_BACK = 2'd2;
    localparam logic [1:0] MODE_AUTO = 2'd3;

    localparam logic [1:0] END_NONE  = 2'd0;
    localparam logic [1:0] END_FRONT = 2'd1;
    localparam logic [1:0] END_BACK  = 2'd2;

    localparam int         CFG_INDEX_BITS    = 1;
    localparam logic [0:0] CFG_DETECT_LEVEL  = 1'b0;
    localparam logic [0:0] CFG_FORWARD_LIMIT = 1'b1;

    localparam logic [9:0] DETECT_RESET = 10'd1023;

    typedef struct packed {
        logic [1:0] run_mode;
        logic [1:0] motion;
        logic [1:0] last_end;
        logic       encoder_previous;
        logic       forward_drive;
        logic       backward_drive;
    } t_ctrl;

endpackage

FILE: hw/rtl/smec_if.sv
// ----------------------------------------------------------------------------
// smec_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface smec_in_if #(
    parameter int SAMPLE_BITS = 10
) ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             cmd;
    logic [1:0]             new_mode;
    logic [SAMPLE_BITS-1:0] front_level;
    logic [SAMPLE_BITS-1:0] back_level;
    logic                   encoder_pin;

    modport source (
        output valid, cmd, new_mode, front_level, back_level, encoder_pin,
        input  ready
    );
    modport sink (
        input  valid, cmd, new_mode, front_level, back_level, encoder_pin,
        output ready
    );
endinterface

interface smec_out_if #(
    parameter int COUNT_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         drive_forward;
    logic                         drive_backward;
    logic [1:0]                   motion_status;
    logic [1:0]                   mode_now;
    logic signed [COUNT_BITS-1:0] encoder_count;

    modport source (
        output valid, drive_forward, drive_backward, motion_status, mode_now,
               encoder_count,
        input  ready
    );
    modport sink (
        input  valid, drive_forward, drive_backward, motion_status, mode_now,
               encoder_count,
        output ready
    );
endinterface

FILE: hw/rtl/smec_cfg_regs.sv
// ----------------------------------------------------------------------------
// smec_cfg_regs
// Detect level and forward limit registers behind the write port.
// ----------------------------------------------------------------------------
module smec_cfg_regs #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16,
    parameter int CFG_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smec_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]                 i_cfg_data,
    output logic [SAMPLE_BITS-1:0]              o_detect_level,
    output logic signed [COUNT_BITS-1:0]        o_forward_limit
);

    logic [SAMPLE_BITS-1:0]       r_detect_level;
    logic signed [COUNT_BITS-1:0] r_forward_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_level  <= SAMPLE_BITS'(smec_pkg::DETECT_RESET);
            r_forward_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                smec_pkg::CFG_DETECT_LEVEL: begin
                    r_detect_level <= i_cfg_data[SAMPLE_BITS-1:0];
                end
                smec_pkg::CFG_FORWARD_LIMIT: begin
                    r_forward_limit <= $signed(i_cfg_data[COUNT_BITS-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_detect_level  = r_detect_level;
    assign o_forward_limit = r_forward_limit;

endmodule

FILE: hw/rtl/smec_step.sv
// ----------------------------------------------------------------------------
// smec_step
// Next-state logic for one command item: end detection, mode handling,
// encoder edge counting and count clearing.
// ----------------------------------------------------------------------------
module smec_step #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  smec_pkg::t_ctrl               i_ctrl,
    input  logic signed [COUNT_BITS-1:0]  i_count,
    input  logic [1:0]                    i_cmd,
    input  logic [1:0]                    i_new_mode,
    input  logic [SAMPLE_BITS-1:0]        i_front_level,
    input  logic [SAMPLE_BITS-1:0]        i_back_level,
    input  logic                          i_encoder_pin,
    input  logic [SAMPLE_BITS-1:0]        i_detect_level,
    input  logic signed [COUNT_BITS-1:0]  i_forward_limit,
    output smec_pkg::t_ctrl               o_ctrl,
    output logic signed [COUNT_BITS-1:0]  o_count
);

    logic front_hit;
    logic back_hit;
    logic limit_hit;

    assign front_hit = (i_front_level >= i_detect_level);
    assign back_hit  = (i_back_level >= i_detect_level);
    assign limit_hit = (i_ctrl.motion == smec_pkg::MODE_FWD) && (i_count >= i_forward_limit);

    always_comb begin
        smec_pkg::t_ctrl             c;
        logic signed [COUNT_BITS-1:0] n;
        logic                        run_fwd;
        logic                        run_back;
        c        = i_ctrl;
        n        = i_count;
        run_fwd  = 1'b0;
        run_back = 1'b0;
        case (i_cmd)
            smec_pkg::CMD_TICK: begin
                if (limit_hit) begin
                    c.last_end = smec_pkg::END_FRONT;
                end
                case (i_ctrl.run_mode)
                    smec_pkg::MODE_STOP: begin
                        c.motion         = smec_pkg::MODE_STOP;
                        c.forward_drive  = 1'b0;
                        c.backward_drive = 1'b0;
                    end
                    smec_pkg::MODE_FWD: begin
                        run_fwd = 1'b1;
                    end
                    smec_pkg::MODE_BACK: begin
                        run_back = 1'b1;
                    end
                    default: begin
                        if (c.last_end == smec_pkg::END_FRONT) begin
                            run_back = 1'b1;
                        end else begin
                            run_fwd = 1'b1;
                        end
                    end
                endcase
                if (run_fwd) begin
                    c.motion         = smec_pkg::MODE_FWD;
                    c.forward_drive  = 1'b1;
                    c.backward_drive = 1'b0;
                    if (front_hit) begin
                        c.run_mode      = smec_pkg::MODE_STOP;
                        c.motion        = smec_pkg::MODE_STOP;
                        c.last_end      = smec_pkg::END_FRONT;
                        c.forward_drive = 1'b0;
                    end
                end
                if (run_back) begin
                    c.motion         = smec_pkg::MODE_BACK;
                    c.forward_drive  = 1'b0;
                    c.backward_drive = 1'b1;
                    if (back_hit) begin
                        c.run_mode       = smec_pkg::MODE_STOP;
                        c.motion         = smec_pkg::MODE_STOP;
                        c.last_end       = smec_pkg::END_BACK;
                        c.backward_drive = 1'b0;
                        n                = '0;
                    end
                end
                if (i_ctrl.run_mode == smec_pkg::MODE_AUTO) begin
                    c.run_mode = smec_pkg::MODE_AUTO;
                end
                if (i_encoder_pin != i_ctrl.encoder_previous) begin
                    if (c.motion == smec_pkg::MODE_FWD) begin
                        n = n + COUNT_BITS'(1);
                    end else if (c.motion == smec_pkg::MODE_BACK) begin
                        n = n - COUNT_BITS'(1);
                    end
                end
                c.encoder_previous = i_encoder_pin;
            end
            smec_pkg::CMD_SET_MODE: begin
                c.run_mode = i_new_mode;
                if (i_new_mode != smec_pkg::MODE_AUTO) begin
                    c.motion = i_new_mode;
                end
            end
            smec_pkg::CMD_CLEAR: begin
                n = '0;
            end
            default: begin
            end
        endcase
        o_ctrl  = c;
        o_count = n;
    end

endmodule

FILE: hw/rtl/shuttle_motor_endstop_controller_core.sv
// ----------------------------------------------------------------------------
// shuttle_motor_endstop_controller_core
// Two-direction motor control with front and back end sensors, auto
// shuttling and a single-pin encoder count.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake           Payload
//  i_in      in   valid/ready         cmd, new_mode, front_level, back_level,
//                                     encoder_pin
//  o_out     out  valid/ready         drive_forward, drive_backward,
//                                     motion_status, mode_now, encoder_count
//  i_cfg_*   in   write enable only   detect_level (0), forward_limit (1)
//
// One item per cycle sustained while results are taken; each item is held in
// the input register, and its result is then registered in the result
// register, from which it is offered.
// Synchronous active-low reset clears control state, count and valid bits.
// A stalled result holds in the result register while one more item waits in
// the input register; the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module shuttle_motor_endstop_controller_core #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    smec_in_if.sink                             i_in,
    smec_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [smec_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [((SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS)-1:0] i_cfg_data
);

    localparam int CFG_BITS = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;

    logic [SAMPLE_BITS-1:0]       detect_level;
    logic signed [COUNT_BITS-1:0] forward_limit;

    logic                   r_in_valid;
    logic [1:0]             r_in_cmd;
    logic [1:0]             r_in_new_mode;
    logic [SAMPLE_BITS-1:0] r_in_front;
    logic [SAMPLE_BITS-1:0] r_in_back;
    logic                   r_in_pin;

    smec_pkg::t_ctrl              r_ctrl;
    smec_pkg::t_ctrl              n_ctrl;
    logic signed [COUNT_BITS-1:0] r_count;
    logic signed [COUNT_BITS-1:0] n_count;

    logic                         r_out_valid;
    smec_pkg::t_ctrl              r_out_ctrl;
    logic signed [COUNT_BITS-1:0] r_out_count;

    logic advance;
    logic in_accept;

    smec_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_detect_level  (detect_level),
        .o_forward_limit (forward_limit)
    );

    smec_step #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_step (
        .i_ctrl          (r_ctrl),
        .i_count         (r_count),
        .i_cmd           (r_in_cmd),
        .i_new_mode      (r_in_new_mode),
        .i_front_level   (r_in_front),
        .i_back_level    (r_in_back),
        .i_encoder_pin   (r_in_pin),
        .i_detect_level  (detect_level),
        .i_forward_limit (forward_limit),
        .o_ctrl          (n_ctrl),
        .o_count         (n_count)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_accept  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl      <= '{run_mode: smec_pkg::MODE_STOP, motion: smec_pkg::MODE_STOP,
                             last_end: smec_pkg::END_NONE, encoder_previous: 1'b0,
                             forward_drive: 1'b0, backward_drive: 1'b0};
            r_count     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctrl      <= n_ctrl;
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_cmd      <= i_in.cmd;
            r_in_new_mode <= i_in.new_mode;
            r_in_front    <= i_in.front_level;
            r_in_back     <= i_in.back_level;
            r_in_pin      <= i_in.encoder_pin;
        end
        if (advance) begin
            r_out_ctrl  <= n_ctrl;
            r_out_count <= n_count;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.drive_forward  = r_out_ctrl.forward_drive;
    assign o_out.drive_backward = r_out_ctrl.backward_drive;
    assign o_out.motion_status  = r_out_ctrl.motion;
    assign o_out.mode_now       = r_out_ctrl.run_mode;
    assign o_out.encoder_count  = r_out_count;

endmodule

FILE: hw/rtl/smec_checker.sv
// ----------------------------------------------------------------------------
// smec_assertions
// Port-level checks on the controller's result channel and reset behavior.
// ----------------------------------------------------------------------------
module smec_assertions #(
    parameter int COUNT_BITS = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_drive_forward,
    input logic                  i_drive_backward,
    input logic [1:0]            i_motion_status,
    input logic [COUNT_BITS-1:0] i_encoder_count
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("pipeline not empty after reset");

    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_stall_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_encoder_count))
        else $error("stalled result changed");

    a_one_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_drive_forward && i_drive_backward))
        else $error("both drive outputs high");

    a_motion_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_motion_status != smec_pkg::MODE_AUTO)
        else $error("motion reports auto");

endmodule

bind shuttle_motor_endstop_controller_core smec_assertions #(
    .COUNT_BITS (COUNT_BITS)
) u_smec_assertions (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_drive_forward  (o_out.drive_forward),
    .i_drive_backward (o_out.drive_backward),
    .i_motion_status  (o_out.motion_status),
    .i_encoder_count  (o_out.encoder_count)
);
